// ===== src/prdb_pkg.sv =====
package prdb_pkg;

  localparam int TIME_FIELD_W   = 32;
  localparam int POWER_INT_BITS = 16;
  localparam int REG_IDX_W      = 3;
  localparam int DB_W           = 16;

  typedef struct packed {
    logic updated;
    logic active;
  } prdb_flags_t;

endpackage

// ===== src/prdb_front.sv =====
module prdb_front #(
  parameter int TIME_BITS       = 32,
  parameter int POWER_FRAC_BITS = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            wr_en_i,
  input  logic [prdb_pkg::REG_IDX_W-1:0]                  wr_idx_i,
  input  logic [prdb_pkg::POWER_INT_BITS+POWER_FRAC_BITS-1:0] wr_data_i,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [prdb_pkg::TIME_FIELD_W-1:0]               in_time_i,
  output logic                                            push_o,
  input  logic                                            push_ready_i,
  output prdb_pkg::prdb_flags_t                           flags_o,
  output logic [prdb_pkg::POWER_INT_BITS+POWER_FRAC_BITS-1:0] level_o
);
  import prdb_pkg::*;

  localparam int PB    = POWER_INT_BITS + POWER_FRAC_BITS;
  localparam int TW    = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
  localparam int DIG_W = 16;
  localparam int NDIG  = (TW + DIG_W - 1) / DIG_W;
  localparam int EW    = NDIG * DIG_W;
  localparam int AW    = PB + EW;
  localparam int CW    = $clog2(NDIG + 1);

  localparam logic [REG_IDX_W-1:0] REG_START_TIME   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_DURATION     = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_START_POWER  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_STOP_POWER   = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SLOPE        = REG_IDX_W'(5);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CLASS = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_LEVEL = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [TW-1:0] start_q, dur_q, minint_q;
  logic [PB-1:0] pstart_q, pstop_q, slope_q;

  logic [2:0]    state_q;
  logic [TW-1:0] last_q, now_q;
  logic          act_q;
  logic [PB-1:0] mag_q;
  logic          neg_q;
  logic [EW-1:0] el_q;
  logic [AW-1:0] acc_q;
  logic [CW-1:0] cnt_q;
  logic [PB-1:0] lvl_q;
  prdb_flags_t   fl_q;

  logic              held;
  logic [TW-1:0]     elapsed;
  logic              at_end;
  logic [PB-1:0]     slope_mag;
  logic [DIG_W-1:0]  digit;
  logic [PB+DIG_W-1:0] pp;
  logic [AW-1:0]     acc_next;
  logic              big;
  logic [PB-1:0]     prod;
  logic [PB:0]       sum;
  logic [PB-1:0]     level_mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      dur_q    <= TW'(1);
      minint_q <= '0;
      pstart_q <= PB'(1) << POWER_FRAC_BITS;
      pstop_q  <= PB'(1) << POWER_FRAC_BITS;
      slope_q  <= '0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_START_TIME:   start_q  <= wr_data_i[TW-1:0];
        REG_DURATION:     dur_q    <= wr_data_i[TW-1:0];
        REG_MIN_INTERVAL: minint_q <= wr_data_i[TW-1:0];
        REG_START_POWER:  pstart_q <= wr_data_i;
        REG_STOP_POWER:   pstop_q  <= wr_data_i;
        REG_SLOPE:        slope_q  <= wr_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    held      = (minint_q != '0) && ((now_q < last_q) || ((now_q - last_q) < minint_q));
    elapsed   = (now_q > start_q) ? (now_q - start_q) : '0;
    at_end    = elapsed >= dur_q;
    slope_mag = slope_q[PB-1] ? (~slope_q + PB'(1)) : slope_q;
    digit     = el_q[EW-1 -: DIG_W];
    pp        = mag_q * digit;
    acc_next  = (acc_q << DIG_W) + AW'(pp);
    big       = |acc_q[AW-1:PB];
    prod      = acc_q[PB-1:0];
    sum       = {1'b0, pstart_q} + {1'b0, prod};
    if (!neg_q) begin
      level_mul = (big || (prod >= pstart_q)) ? '0 : (pstart_q - prod);
    end else begin
      level_mul = (big || sum[PB]) ? '1 : sum[PB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      last_q  <= '0;
      act_q   <= 1'b0;
      now_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      el_q    <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      lvl_q   <= '0;
      fl_q    <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            now_q   <= in_time_i[TW-1:0];
            state_q <= F_CLASS;
          end
        end
        F_CLASS: begin
          if (held) begin
            fl_q.updated <= 1'b0;
            fl_q.active  <= act_q;
            lvl_q        <= '0;
            state_q      <= F_PUSH;
          end else begin
            last_q <= now_q;
            if (at_end) begin
              act_q        <= 1'b0;
              fl_q.updated <= 1'b1;
              fl_q.active  <= 1'b0;
              lvl_q        <= pstop_q;
              state_q      <= F_PUSH;
            end else begin
              act_q   <= 1'b1;
              mag_q   <= slope_mag;
              neg_q   <= slope_q[PB-1];
              el_q    <= EW'(elapsed);
              acc_q   <= '0;
              cnt_q   <= CW'(NDIG);
              state_q <= F_MUL;
            end
          end
        end
        F_MUL: begin
          acc_q <= acc_next;
          el_q  <= el_q << DIG_W;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= F_LEVEL;
          end
        end
        F_LEVEL: begin
          lvl_q        <= level_mul;
          fl_q.updated <= 1'b1;
          fl_q.active  <= 1'b1;
          state_q      <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH);
  assign flags_o    = fl_q;
  assign level_o    = lvl_q;

endmodule

// ===== src/prdb_fifo.sv =====
module prdb_fifo #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != NW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

// ===== src/prdb_back.sv =====
module prdb_back #(
  parameter int POWER_FRAC_BITS = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            pop_valid_i,
  output logic                                            pop_o,
  input  prdb_pkg::prdb_flags_t                           flags_i,
  input  logic [prdb_pkg::POWER_INT_BITS+POWER_FRAC_BITS-1:0] level_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [prdb_pkg::DB_W-1:0]                       out_db_o,
  output prdb_pkg::prdb_flags_t                           out_flags_o
);
  import prdb_pkg::*;

  localparam int PB         = POWER_INT_BITS + POWER_FRAC_BITS;
  localparam int K          = $clog2(PB);
  localparam int SC_W       = $clog2(K);
  localparam int MANT_W     = 31;
  localparam int LOG_STEPS  = 16;
  localparam int LC_W       = $clog2(LOG_STEPS);
  localparam int LGI_W      = $clog2(POWER_FRAC_BITS + 1) + 1;
  localparam int LG_W       = LGI_W + LOG_STEPS;
  localparam int DB_SCALE_W = 27;
  localparam int PR_W       = LG_W + DB_SCALE_W;
  localparam int RND_SHIFT  = 32;
  localparam int RN_W       = PR_W - RND_SHIFT;

  localparam logic signed [DB_SCALE_W-1:0] DB_SCALE = 27'sd50504453;
  localparam logic [DB_W-1:0] DB_MIN = 16'h8000;
  localparam logic [DB_W-1:0] DB_MAX = 16'h7fff;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_NORM = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_RND  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]             state_q;
  prdb_flags_t            fl_q;
  logic [PB-1:0]          n_q;
  logic [K-1:0]           sh_q;
  logic [SC_W-1:0]        step_q;
  logic [MANT_W-1:0]      m_q;
  logic [LOG_STEPS-1:0]   frac_q;
  logic [LC_W-1:0]        sqcnt_q;
  logic signed [PR_W-1:0] prod_q;
  logic [DB_W-1:0]        db_q;
  logic                   ovalid_q;
  logic [DB_W-1:0]        odb_q;
  prdb_flags_t            ofl_q;

  logic [K:0]              amt;
  logic [K:0]              shr;
  logic                    zero_top;
  logic [PB-1:0]           n_next;
  logic [2*MANT_W-1:0]     sq;
  logic [MANT_W:0]         sqs;
  logic signed [LGI_W-1:0] lgi;
  logic signed [LG_W-1:0]  lg;
  logic signed [PR_W-1:0]  prod_d;
  logic                    neg;
  logic [PR_W-1:0]         mag;
  logic [PR_W-1:0]         rsum;
  logic [RN_W-1:0]         rnd;
  logic [DB_W-1:0]         db_d;
  logic                    load_out;

  always_comb begin
    amt      = (K + 1)'(1) << step_q;
    shr      = (K + 1)'(PB) - amt;
    zero_top = ((n_q >> shr) == '0);
    n_next   = zero_top ? (n_q << amt) : n_q;
    sq       = m_q * m_q;
    sqs      = sq[2*MANT_W-1:MANT_W-1];
    lgi      = LGI_W'(POWER_INT_BITS - 1) - LGI_W'(sh_q);
    lg       = {lgi, frac_q};
    prod_d   = lg * DB_SCALE;
    neg      = prod_q[PR_W-1];
    mag      = neg ? (PR_W'(0) - prod_q) : prod_q;
    rsum     = mag + (PR_W'(1) << (RND_SHIFT - 1));
    rnd      = rsum[PR_W-1:RND_SHIFT];
    if (neg) begin
      db_d = (rnd > RN_W'(32768)) ? DB_MIN : DB_W'(RN_W'(0) - rnd);
    end else begin
      db_d = (rnd > RN_W'(32767)) ? DB_MAX : DB_W'(rnd);
    end
  end

  assign pop_o    = (state_q == B_IDLE);
  assign load_out = (state_q == B_OUT) && (!ovalid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      fl_q     <= '0;
      n_q      <= '0;
      sh_q     <= '0;
      step_q   <= '0;
      m_q      <= '0;
      frac_q   <= '0;
      sqcnt_q  <= '0;
      prod_q   <= '0;
      db_q     <= '0;
      ovalid_q <= 1'b0;
      odb_q    <= '0;
      ofl_q    <= '0;
    end else begin
      if (load_out) begin
        ovalid_q <= 1'b1;
        odb_q    <= db_q;
        ofl_q    <= fl_q;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            fl_q <= flags_i;
            if (!flags_i.updated) begin
              db_q    <= '0;
              state_q <= B_OUT;
            end else if (level_i == '0) begin
              db_q    <= DB_MIN;
              state_q <= B_OUT;
            end else begin
              n_q     <= level_i;
              sh_q    <= '0;
              step_q  <= SC_W'(K - 1);
              state_q <= B_NORM;
            end
          end
        end
        B_NORM: begin
          n_q <= n_next;
          if (zero_top) begin
            sh_q <= sh_q + K'(amt);
          end
          step_q <= step_q - SC_W'(1);
          if (step_q == '0) begin
            m_q     <= n_next[PB-1 -: MANT_W];
            frac_q  <= '0;
            sqcnt_q <= LC_W'(LOG_STEPS - 1);
            state_q <= B_SQ;
          end
        end
        B_SQ: begin
          m_q     <= sqs[MANT_W] ? sqs[MANT_W:1] : sqs[MANT_W-1:0];
          frac_q  <= {frac_q[LOG_STEPS-2:0], sqs[MANT_W]};
          sqcnt_q <= sqcnt_q - LC_W'(1);
          if (sqcnt_q == '0) begin
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          prod_q  <= prod_d;
          state_q <= B_RND;
        end
        B_RND: begin
          db_q    <= db_d;
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (load_out) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_db_o    = odb_q;
  assign out_flags_o = ofl_q;

endmodule

// ===== src/power_ramp_with_db_output.sv =====
// Linear power ramp with a dB readout.
// Input stream: each request on s_axis carries the current tick in s_axis_tdata.
// Output stream: one result per input request. m_axis_tuser is the updated flag;
// m_axis_tdata holds the level in dB (signed Q7.8) and the ramp-active flag.
// Registers are loaded through wr_en_i / wr_idx_i / wr_data_i; the user must
// load them only while idle, since the block itself does not enforce this.
// A front part applies the rate limit, tracks the ramp and forms the power
// level (one 16-bit digit of elapsed time per cycle into a power-wide
// multiply-accumulate), then queues it in a 2-entry FIFO. A back part turns
// the level into dB: leading-one normalization in log2(power width) steps,
// 16 squaring steps for the log2 fraction, one scale multiply, one rounding.
// An end-of-ramp level skips the front multiply. The back part takes no new
// level until it has finished the last one; held or zero-level requests
// skip its normalization, squaring, multiply and rounding.
// Reset loads the register defaults, clears the last-update tick and the
// active flag, and empties the queue. When the receiver stalls, the result
// holds in the output register, the back part finishes one more item, and the
// front keeps taking requests until the queue fills.
module power_ramp_with_db_output #(
  parameter int TIME_BITS       = 32,
  parameter int POWER_FRAC_BITS = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            wr_en_i,
  input  logic [prdb_pkg::REG_IDX_W-1:0]                  wr_idx_i,
  input  logic [prdb_pkg::POWER_INT_BITS+POWER_FRAC_BITS-1:0] wr_data_i,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // [31:0] now_time
  input  logic [prdb_pkg::TIME_FIELD_W-1:0]               s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // [15:0] level_db, [16] ramp_active, [23:17] zero
  output logic [23:0]                                     m_axis_tdata,
  // [0] updated
  output logic                                            m_axis_tuser
);
  import prdb_pkg::*;

  localparam int PB = POWER_INT_BITS + POWER_FRAC_BITS;
  localparam int FW = $bits(prdb_flags_t);
  localparam int QW = PB + FW;

  logic          f_push, q_wready, q_rvalid, b_pop;
  prdb_flags_t   f_flags, b_flags, o_flags;
  logic [PB-1:0] f_level, b_level;
  logic [QW-1:0] q_rdata;
  logic [DB_W-1:0] o_db;

  prdb_front #(
    .TIME_BITS      (TIME_BITS),
    .POWER_FRAC_BITS(POWER_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en_i),
    .wr_idx_i    (wr_idx_i),
    .wr_data_i   (wr_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_time_i   (s_axis_tdata),
    .push_o      (f_push),
    .push_ready_i(q_wready),
    .flags_o     (f_flags),
    .level_o     (f_level)
  );

  prdb_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_push),
    .wr_ready_o(q_wready),
    .wr_data_i ({f_flags, f_level}),
    .rd_valid_o(q_rvalid),
    .rd_ready_i(b_pop),
    .rd_data_o (q_rdata)
  );

  assign b_flags = prdb_flags_t'(q_rdata[QW-1 -: FW]);
  assign b_level = q_rdata[PB-1:0];

  prdb_back #(
    .POWER_FRAC_BITS(POWER_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(q_rvalid),
    .pop_o      (b_pop),
    .flags_i    (b_flags),
    .level_i    (b_level),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_db_o   (o_db),
    .out_flags_o(o_flags)
  );

  assign m_axis_tdata = {7'b0, o_flags.active, o_db};
  assign m_axis_tuser = o_flags.updated;

  a_held_zero_db: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == 16'h0000))
    else $error("held result carries nonzero level");

  a_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_push && !q_wready) |=> (f_push && $stable(f_level) && $stable(f_flags)))
    else $error("front request changed while queue full");

  a_queue_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_rvalid && !b_pop) |=> q_rvalid)
    else $error("queue lost an entry");

endmodule

// ===== test/ramp_tb_pkg.sv =====
`timescale 1ns / 1ps

package ramp_tb_pkg;

  typedef enum logic [prdb_pkg::REG_IDX_W-1:0] {
    REG_START_TIME,
    REG_DURATION,
    REG_MIN_INTERVAL,
    REG_START_POWER,
    REG_STOP_POWER,
    REG_SLOPE,
    REG_SPARE_A,
    REG_SPARE_B
  } ramp_reg_e;

endpackage

// ===== test/ramp_db_checker.sv =====
`timescale 1ns / 1ps

module ramp_db_checker #(
  parameter int POWER_FRAC_BITS = 32
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                wr_en_i,
  input  logic [prdb_pkg::REG_IDX_W-1:0]                      wr_idx_i,
  input  logic [prdb_pkg::POWER_INT_BITS+POWER_FRAC_BITS-1:0] wr_data_i,
  input  logic                                                s_valid_i,
  input  logic                                                s_ready_i,
  input  logic [prdb_pkg::TIME_FIELD_W-1:0]                   s_data_i,
  input  logic                                                m_valid_i,
  input  logic                                                m_ready_i,
  input  logic [23:0]                                         m_data_i,
  input  logic                                                m_user_i,
  output int                                                  fail_count_o,
  output int                                                  pending_o
);
  import ramp_tb_pkg::*;

  localparam int PW = prdb_pkg::POWER_INT_BITS + POWER_FRAC_BITS;
  localparam logic [PW-1:0] PMAX = '1;
  localparam longint DB_SCALE = 50504453;  // 10*log10(2) in Q.24
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic        updated;
    logic [15:0] level;
    logic        active;
  } ramp_result_t;

  logic [31:0]   ramp_t0, ramp_len, hold_ticks, last_tick;
  logic [PW-1:0] p_begin, p_end, p_slope;
  logic          running;
  ramp_result_t  expected_q[$];
  int            fails;

  function automatic logic [15:0] power_db(input logic [PW-1:0] p);
    int          msb;
    int          b;
    logic [63:0] m;
    logic [15:0] frac;
    longint      lg, prod, mag;
    if (p == '0) return 16'h8000;
    msb = 0;
    for (b = 0; b < PW; b++) if (p[b]) msb = b;
    m = 64'(p);
    if (msb >= 30) m = m >> (msb - 30);
    else m = m << (30 - msb);
    frac = '0;
    repeat (16) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    lg = longint'(msb - POWER_FRAC_BITS) * 65536 + longint'(frac);
    prod = lg * DB_SCALE;
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (longint'(1) << 31)) >>> 32;
    if (prod < 0) mag = -mag;
    if (mag < -32768) return 16'h8000;
    if (mag > 32767) return 16'h7fff;
    return mag[15:0];
  endfunction

  function automatic ramp_result_t step_ramp(input logic [31:0] now);
    ramp_result_t   r;
    logic [31:0]    el;
    logic [PW-1:0]  lvl, mag;
    logic [PW+31:0] full;
    logic           neg, big;
    r = '0;
    if (hold_ticks != 0 && (now < last_tick || now - last_tick < hold_ticks)) begin
      r.active = running;
      return r;
    end
    last_tick = now;
    el = (now > ramp_t0) ? now - ramp_t0 : '0;
    if (el >= ramp_len) begin
      lvl = p_end;
      running = 1'b0;
    end else begin
      neg = p_slope[PW-1];
      mag = neg ? -p_slope : p_slope;
      full = mag * el;
      big = full > (PW+32)'(PMAX);
      if (!neg) lvl = (big || full[PW-1:0] >= p_begin) ? '0 : p_begin - full[PW-1:0];
      else lvl = (big || full[PW-1:0] > PMAX - p_begin) ? PMAX : p_begin + full[PW-1:0];
      running = 1'b1;
    end
    r.updated = 1'b1;
    r.level = power_db(lvl);
    r.active = running;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ramp_result_t want;
    if (!rst_ni) begin
      ramp_t0 = '0;
      ramp_len = 32'd1;
      hold_ticks = '0;
      p_begin = PW'(1) << POWER_FRAC_BITS;
      p_end = PW'(1) << POWER_FRAC_BITS;
      p_slope = '0;
      last_tick = '0;
      running = 1'b0;
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (wr_en_i) begin
        case (ramp_reg_e'(wr_idx_i))
          REG_START_TIME:   ramp_t0 = wr_data_i[31:0];
          REG_DURATION:     ramp_len = wr_data_i[31:0];
          REG_MIN_INTERVAL: hold_ticks = wr_data_i[31:0];
          REG_START_POWER:  p_begin = wr_data_i;
          REG_STOP_POWER:   p_end = wr_data_i;
          REG_SLOPE:        p_slope = wr_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) expected_q.push_back(step_ramp(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: result with no request pending: upd=%0b db=%0d act=%0b",
                     $realtime, m_user_i, $signed(m_data_i[15:0]), m_data_i[16]);
        end else begin
          want = expected_q.pop_front();
          if (m_user_i !== want.updated || m_data_i[15:0] !== want.level ||
              m_data_i[16] !== want.active) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("%0t: mismatch: expected upd=%0b db=%0d act=%0b, got upd=%0b db=%0d act=%0b",
                       $realtime, want.updated, $signed(want.level), want.active,
                       m_user_i, $signed(m_data_i[15:0]), m_data_i[16]);
          end
        end
      end
      fail_count_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import prdb_pkg::*;
  import ramp_tb_pkg::*;

  localparam int PW = POWER_INT_BITS + 32;
  localparam logic [PW-1:0] PMAX = '1;
  localparam logic [PW-1:0] ONE = PW'(1) << 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_idx = '0;
  logic [PW-1:0]        wr_data = '0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [31:0]          s_data = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [23:0]          m_data;
  logic                 m_user;
  int                   fail_count, pending;
  bit                   gaps_on = 1'b1;
  int                   stall_left = 0;
  int                   idle_cycles = 0;

  power_ramp_with_db_output dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .wr_idx_i      (wr_idx),
    .wr_data_i     (wr_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  ramp_db_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_idx_i     (wr_idx),
    .wr_data_i    (wr_data),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .m_user_i     (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("power_ramp_with_db_output regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input ramp_reg_e idx, input logic [PW-1:0] val);
    @(posedge clk_i);
    wr_en <= 1'b1;
    wr_idx <= idx;
    wr_data <= val;
    @(posedge clk_i);
    wr_en <= 1'b0;
  endtask

  task automatic send_tick(input logic [31:0] t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= t;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // stop sending, wait for every outstanding result, then let the pipe empty
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PW-1:0] rand_wide();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  function automatic logic [PW-1:0] rand_power();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PMAX;
      2: return PW'(1);
      default: return {16'($urandom_range(0, 255)), 32'($urandom)};
    endcase
  endfunction

  task automatic load_random_ramp(output logic [31:0] pace, output logic [31:0] origin);
    logic [31:0]   t0, len, gap;
    logic [PW-1:0] p0, p1, k;
    longint        diff;
    t0 = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
    case ($urandom_range(0, 7))
      0: len = '0;
      1: len = 32'd1;
      2: len = '1;
      default: len = $urandom_range(2, 20000);
    endcase
    p0 = rand_power();
    p1 = rand_power();
    if (len == 0 || $urandom_range(0, 4) == 0) begin
      k = rand_wide();
    end else begin
      diff = longint'(p0) - longint'(p1);
      k = PW'(diff / longint'(len));
    end
    case ($urandom_range(0, 7))
      0, 1, 2: gap = '0;
      3: gap = '1;
      default: gap = $urandom_range(1, len / 16 + 1);
    endcase
    pace = (len >> 5) + 1;
    if (gap > pace && gap < 32'h1000_0000) pace = gap;
    origin = t0 - 3 * pace;
    write_reg(REG_START_TIME, {16'($urandom_range(0, 65535)), t0});
    write_reg(REG_DURATION, {16'($urandom_range(0, 65535)), len});
    write_reg(REG_MIN_INTERVAL, {16'($urandom_range(0, 65535)), gap});
    write_reg(REG_START_POWER, p0);
    write_reg(REG_STOP_POWER, p1);
    write_reg(REG_SLOPE, k);
    if ($urandom_range(0, 3) == 0)
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, rand_wide());
  endtask

  initial begin
    logic [31:0] t, pace;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: unit power, one-tick ramp
    send_tick(32'd0);
    send_tick('1);
    settle();

    // falling ramp to zero power, including ticks before the start
    write_reg(REG_START_TIME, PW'(100));
    write_reg(REG_DURATION, PW'(1000));
    write_reg(REG_MIN_INTERVAL, '0);
    write_reg(REG_START_POWER, ONE);
    write_reg(REG_STOP_POWER, '0);
    write_reg(REG_SLOPE, ONE / 1000);
    write_reg(REG_SPARE_A, rand_wide());
    write_reg(REG_SPARE_B, rand_wide());
    send_tick(32'd50);
    send_tick(32'd100);
    send_tick(32'd600);
    send_tick(32'd1099);
    send_tick(32'd1100);
    settle();

    // rate limit: too soon, exactly on time, backwards
    write_reg(REG_MIN_INTERVAL, PW'(10));
    send_tick(32'd1105);
    send_tick(32'd1110);
    send_tick(32'd1000);
    send_tick(32'd1120);
    settle();

    // zero duration, top of the power range
    write_reg(REG_MIN_INTERVAL, '0);
    write_reg(REG_DURATION, '0);
    write_reg(REG_STOP_POWER, PMAX);
    send_tick(32'd0);
    send_tick(32'd7);
    settle();

    // most negative slope: power overflows and clamps
    write_reg(REG_START_TIME, '0);
    write_reg(REG_DURATION, PW'(32'hffff_ffff));
    write_reg(REG_START_POWER, PMAX >> 1);
    write_reg(REG_SLOPE, {1'b1, {(PW-1){1'b0}}});
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd3);
    settle();

    // largest positive slope: smallest power, then underflow; held while active
    write_reg(REG_START_POWER, PW'(1));
    write_reg(REG_SLOPE, {1'b0, {(PW-1){1'b1}}});
    send_tick(32'd0);
    send_tick(32'd2);
    settle();
    write_reg(REG_MIN_INTERVAL, PW'(1000));
    send_tick(32'd5);
    settle();

    // zero power, start at the last tick, widest interval
    write_reg(REG_MIN_INTERVAL, '0);
    write_reg(REG_START_TIME, PW'(32'hffff_ffff));
    write_reg(REG_START_POWER, '0);
    write_reg(REG_SLOPE, '0);
    send_tick(32'd9);
    send_tick('1);
    settle();
    write_reg(REG_MIN_INTERVAL, PW'(32'hffff_ffff));
    send_tick(32'd0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      gaps_on = (ph < 10) && (ph % 4 != 3);
      load_random_ramp(pace, t);
      for (int n = 0; n < 90; n++) begin
        case ($urandom_range(0, 19))
          0: t = $urandom;
          1: t = t - $urandom_range(0, pace);
          default: t = t + $urandom_range(0, 2 * pace);
        endcase
        send_tick(t);
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("power_ramp_with_db_output regression: pass");
    end else begin
      $display("power_ramp_with_db_output regression: fail");
    end
    $finish;
  end

endmodule
